/* rtl/scored_sector_cache_directory_assert.svh */
// Assertion macros for the scored sector cache directory.
// Each macro checks one implication on the rising clock edge, outside reset.
`ifndef SCORED_SECTOR_CACHE_DIRECTORY_ASSERT_SVH
`define SCORED_SECTOR_CACHE_DIRECTORY_ASSERT_SVH

// Same-cycle implication
`define SSD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ssd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared constants, codes and types of the scored sector cache directory.
// ----------------------------------------------------------------------------
package ssd_pkg;

    localparam int SLOTS_DEF  = 64;
    localparam int SEC_W      = 32;
    localparam int CNT_W      = 6;
    localparam int OP_W       = 2;
    localparam int SLOT_OUT_W = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_W      = 6;
    localparam int SCORE_W    = 13;

    localparam logic [CNT_W-1:0] COUNT_MAX = 6'd63;

    // Opcodes
    localparam logic [OP_W-1:0] OP_READ   = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
    localparam logic [OP_W-1:0] OP_FLUSH  = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCESS_WEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRTY_WEIGHT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_META_WEIGHT  = 2'd3;

    // Register reset values
    localparam logic [CFG_W-1:0] INIT_COUNT_RST    = 6'd5;
    localparam logic [CFG_W-1:0] ACCESS_WEIGHT_RST = 6'd5;
    localparam logic [CFG_W-1:0] DIRTY_WEIGHT_RST  = 6'd1;
    localparam logic [CFG_W-1:0] META_WEIGHT_RST   = 6'd32;

    // Controller to datapath commands
    typedef struct packed {
        logic latch;
        logic rd_en;
        logic lookup_step;
        logic evict_step;
        logic flush_emit;
        logic flush_empty;
        logic finish;
    } ssd_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            found;
        logic            full;
        logic            proc_valid;
        logic            any_valid;
        logic            out_free;
    } ssd_sts_t;

endpackage

/* rtl/ssd_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_req_if
// Request channel: opcode, sector and metadata flag with valid/ready.
// ----------------------------------------------------------------------------
interface ssd_req_if;
    logic                        valid;
    logic                        ready;
    logic [ssd_pkg::OP_W-1:0]    opcode;
    logic [ssd_pkg::SEC_W-1:0]   sector;
    logic                        meta_read;

    modport source (output valid, opcode, sector, meta_read, input ready);
    modport sink   (input valid, opcode, sector, meta_read, output ready);
endinterface

/* rtl/ssd_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_rsp_if
// Result channel: hit, slot, writeback and fill flags with valid/ready.
// ----------------------------------------------------------------------------
interface ssd_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            hit;
    logic [ssd_pkg::SLOT_OUT_W-1:0]  slot;
    logic                            writeback_valid;
    logic [ssd_pkg::SEC_W-1:0]       writeback_sector;
    logic                            fill_needed;
    logic                            last;

    modport source (output valid, hit, slot, writeback_valid, writeback_sector,
                    fill_needed, last, input ready);
    modport sink   (input valid, hit, slot, writeback_valid, writeback_sector,
                    fill_needed, last, output ready);
endinterface

/* rtl/ssd_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_ctrl
// Sequencer: walks the slot memory for lookup, eviction and flush passes.
// ----------------------------------------------------------------------------
module ssd_ctrl #(
    parameter int SLOTS = ssd_pkg::SLOTS_DEF,
    localparam int SLOT_W = $clog2(SLOTS),
    localparam int CW = $clog2(SLOTS + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  ssd_pkg::ssd_sts_t sts,
    output ssd_pkg::ssd_cmd_t cmd,
    output logic [SLOT_W-1:0] rd_addr,
    output logic [SLOT_W-1:0] proc_addr
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_LOOK     = 3'd1;
    localparam logic [2:0] S_EVICT    = 3'd2;
    localparam logic [2:0] S_FIN      = 3'd3;
    localparam logic [2:0] S_FL_RD    = 3'd4;
    localparam logic [2:0] S_FL_CHK   = 3'd5;
    localparam logic [2:0] S_FL_EMPTY = 3'd6;

    localparam logic [CW-1:0] END_C = CW'(SLOTS);

    logic [2:0]        state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              pend_reg, pend_next;
    logic [SLOT_W-1:0] paddr_reg, paddr_next;
    logic              more;
    logic              scan_done;

    assign more      = (cnt_reg != END_C);
    assign scan_done = !pend_reg && !more;
    assign rd_addr   = cnt_reg[SLOT_W-1:0];
    assign proc_addr = paddr_reg;
    assign req_ready = (state_reg == S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pend_next  = pend_reg;
        paddr_next = paddr_reg;
        cmd        = '0;
        unique case (state_reg) inside
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.latch  = 1'b1;
                    cnt_next   = '0;
                    pend_next  = 1'b0;
                    state_next = S_LOOK;
                end
            end
            S_LOOK, S_EVICT:
            begin
                cmd.lookup_step = pend_reg && (state_reg == S_LOOK);
                cmd.evict_step  = pend_reg && (state_reg == S_EVICT);
                cmd.rd_en       = more;
                pend_next       = more;
                paddr_next      = cnt_reg[SLOT_W-1:0];
                if (more)
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
                if (scan_done)
                begin
                    cnt_next = '0;
                    if (state_reg == S_EVICT)
                    begin
                        state_next = S_FIN;
                    end
                    else if (sts.op == ssd_pkg::OP_FLUSH)
                    begin
                        state_next = S_FL_RD;
                    end
                    else if (sts.op != ssd_pkg::OP_REMOVE && !sts.found && sts.full)
                    begin
                        state_next = S_EVICT;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FL_RD:
            begin
                if (!more)
                begin
                    state_next = sts.any_valid ? S_IDLE : S_FL_EMPTY;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    paddr_next = cnt_reg[SLOT_W-1:0];
                    state_next = S_FL_CHK;
                end
            end
            S_FL_CHK:
            begin
                // skip empty slots, emit occupied ones when the output frees up
                if (!sts.proc_valid)
                begin
                    cnt_next   = cnt_reg + CW'(1);
                    state_next = S_FL_RD;
                end
                else if (sts.out_free)
                begin
                    cmd.flush_emit = 1'b1;
                    cnt_next       = cnt_reg + CW'(1);
                    state_next     = S_FL_RD;
                end
            end
            S_FL_EMPTY:
            begin
                if (sts.out_free)
                begin
                    cmd.flush_empty = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            paddr_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            paddr_reg <= paddr_next;
        end
    end

endmodule

/* rtl/ssd_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_dp
// Datapath: slot memory, valid bits, scan trackers, scoring and result register.
// ----------------------------------------------------------------------------
module ssd_dp #(
    parameter int SLOTS = ssd_pkg::SLOTS_DEF,
    localparam int SLOT_W = $clog2(SLOTS),
    localparam int CW = $clog2(SLOTS + 1)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write_en,
    input  logic [ssd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ssd_pkg::CFG_W-1:0]          cfg_data,
    input  logic [ssd_pkg::OP_W-1:0]           in_opcode,
    input  logic [ssd_pkg::SEC_W-1:0]          in_sector,
    input  logic                               in_meta_read,
    input  ssd_pkg::ssd_cmd_t                  cmd,
    input  logic [SLOT_W-1:0]                  rd_addr,
    input  logic [SLOT_W-1:0]                  proc_addr,
    output ssd_pkg::ssd_sts_t                  sts,
    input  logic                               out_ready,
    output logic                               out_valid,
    output logic                               out_hit,
    output logic [ssd_pkg::SLOT_OUT_W-1:0]     out_slot,
    output logic                               out_writeback_valid,
    output logic [ssd_pkg::SEC_W-1:0]          out_writeback_sector,
    output logic                               out_fill_needed,
    output logic                               out_last
);

    localparam int EW = ssd_pkg::SEC_W + ssd_pkg::CNT_W + 2;
    localparam int SW = ssd_pkg::SCORE_W;

    typedef struct packed {
        logic [ssd_pkg::SEC_W-1:0] sector;
        logic [ssd_pkg::CNT_W-1:0] count;
        logic                      dirty;
        logic                      meta;
    } entry_t;

    typedef struct packed {
        logic                           hit;
        logic [ssd_pkg::SLOT_OUT_W-1:0] slot;
        logic                           wbv;
        logic [ssd_pkg::SEC_W-1:0]      wbs;
        logic                           fill;
        logic                           last;
    } result_t;

    function automatic logic [ssd_pkg::CNT_W-1:0] bump(input logic [ssd_pkg::CNT_W-1:0] c);
        bump = (c < ssd_pkg::COUNT_MAX) ? c + ssd_pkg::CNT_W'(1) : c;
    endfunction

    // Configuration
    logic [ssd_pkg::CFG_W-1:0] init_reg, aw_reg, dw_reg, mw_reg;

    // Item
    logic [ssd_pkg::OP_W-1:0]  op_reg;
    logic [ssd_pkg::SEC_W-1:0] sec_reg;
    logic                      meta_in_reg;

    // Slot state
    logic [EW-1:0]     mem [SLOTS];
    entry_t            rd_reg;
    logic [SLOTS-1:0]  valid_reg;
    logic [CW-1:0]     occ_reg;

    // Trackers
    logic              found_reg, free_found_reg, any_reg, have_reg;
    logic [SLOT_W-1:0] found_idx_reg, free_idx_reg, last_idx_reg, victim_idx_reg;
    entry_t            found_ent_reg;
    logic [SW-1:0]     best_reg;
    logic [ssd_pkg::SEC_W-1:0] victim_sec_reg;

    // Result register
    logic    out_valid_reg;
    result_t out_reg;

    logic              pv;
    logic              full;
    logic [SW-1:0]     score;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    entry_t            wr_data;
    logic              out_load;
    result_t           out_next;
    logic [SLOT_W-1:0] target;
    logic              is_miss;

    assign pv      = valid_reg[proc_addr];
    assign full    = (occ_reg == CW'(SLOTS));
    assign target  = full ? victim_idx_reg : free_idx_reg;
    assign is_miss = (op_reg != ssd_pkg::OP_REMOVE) && !found_reg;

    assign score = SW'(rd_reg.count) * SW'(aw_reg)
                 + (rd_reg.dirty ? SW'(dw_reg) : SW'(0))
                 + (rd_reg.meta ? SW'(mw_reg) : SW'(0));

    assign sts.op         = op_reg;
    assign sts.found      = found_reg;
    assign sts.full       = full;
    assign sts.proc_valid = pv;
    assign sts.any_valid  = any_reg;
    assign sts.out_free   = !out_valid_reg || out_ready;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg <= ssd_pkg::INIT_COUNT_RST;
            aw_reg   <= ssd_pkg::ACCESS_WEIGHT_RST;
            dw_reg   <= ssd_pkg::DIRTY_WEIGHT_RST;
            mw_reg   <= ssd_pkg::META_WEIGHT_RST;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                ssd_pkg::CFG_INIT_COUNT:    init_reg <= cfg_data;
                ssd_pkg::CFG_ACCESS_WEIGHT: aw_reg   <= cfg_data;
                ssd_pkg::CFG_DIRTY_WEIGHT:  dw_reg   <= cfg_data;
                ssd_pkg::CFG_META_WEIGHT:   mw_reg   <= cfg_data;
                default:                    init_reg <= init_reg;
            endcase
        end
    end

    // Latch the item
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg      <= in_opcode;
            sec_reg     <= in_sector;
            meta_in_reg <= in_meta_read;
        end
    end

    // Pick the memory write: age, clear dirty, or install/update
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = proc_addr;
        wr_data = rd_reg;
        if (cmd.evict_step && pv)
        begin
            wr_en         = 1'b1;
            wr_data.count = (rd_reg.count != '0) ? rd_reg.count - ssd_pkg::CNT_W'(1) : '0;
        end
        else if (cmd.flush_emit)
        begin
            wr_en         = 1'b1;
            wr_data.dirty = 1'b0;
        end
        else if (cmd.finish && op_reg != ssd_pkg::OP_REMOVE)
        begin
            wr_en = 1'b1;
            if (found_reg)
            begin
                wr_addr       = found_idx_reg;
                wr_data       = found_ent_reg;
                wr_data.count = bump(found_ent_reg.count);
                wr_data.dirty = found_ent_reg.dirty || (op_reg == ssd_pkg::OP_WRITE);
            end
            else
            begin
                wr_addr        = target;
                wr_data.sector = sec_reg;
                wr_data.count  = bump(init_reg);
                wr_data.dirty  = 1'b0;
                wr_data.meta   = (op_reg == ssd_pkg::OP_READ) && meta_in_reg;
            end
        end
    end

    // Slot memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    // Valid bits and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg   <= '0;
        end
        else if (cmd.finish)
        begin
            if (op_reg == ssd_pkg::OP_REMOVE && found_reg)
            begin
                valid_reg[found_idx_reg] <= 1'b0;
                occ_reg                  <= occ_reg - CW'(1);
            end
            else if (is_miss)
            begin
                valid_reg[target] <= 1'b1;
                if (!full)
                begin
                    occ_reg <= occ_reg + CW'(1);
                end
            end
        end
    end

    // Scan trackers: match, first free, last valid, lowest score
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            any_reg        <= 1'b0;
            have_reg       <= 1'b0;
        end
        else if (cmd.latch)
        begin
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            any_reg        <= 1'b0;
            have_reg       <= 1'b0;
        end
        else if (cmd.lookup_step)
        begin
            if (pv && !found_reg && rd_reg.sector == sec_reg)
            begin
                found_reg <= 1'b1;
            end
            if (!pv && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
            end
            if (pv)
            begin
                any_reg <= 1'b1;
            end
        end
        else if (cmd.evict_step && pv && (!have_reg || score < best_reg))
        begin
            have_reg <= 1'b1;
        end
    end

    // Tracker payload
    always_ff @(posedge clk)
    begin
        if (cmd.lookup_step)
        begin
            if (pv && !found_reg && rd_reg.sector == sec_reg)
            begin
                found_idx_reg <= proc_addr;
                found_ent_reg <= rd_reg;
            end
            if (!pv && !free_found_reg)
            begin
                free_idx_reg <= proc_addr;
            end
            if (pv)
            begin
                last_idx_reg <= proc_addr;
            end
        end
        if (cmd.evict_step && pv && (!have_reg || score < best_reg))
        begin
            best_reg       <= score;
            victim_idx_reg <= proc_addr;
            victim_sec_reg <= rd_reg.sector;
        end
    end

    // Build the next result
    always_comb
    begin
        out_load = 1'b0;
        out_next = '0;
        if (cmd.flush_emit)
        begin
            out_load      = 1'b1;
            out_next.slot = ssd_pkg::SLOT_OUT_W'(proc_addr);
            out_next.wbv  = 1'b1;
            out_next.wbs  = rd_reg.sector;
            out_next.last = (proc_addr == last_idx_reg);
        end
        else if (cmd.flush_empty)
        begin
            out_load      = 1'b1;
            out_next.last = 1'b1;
        end
        else if (cmd.finish)
        begin
            out_load      = 1'b1;
            out_next.last = 1'b1;
            if (found_reg)
            begin
                out_next.hit  = 1'b1;
                out_next.slot = ssd_pkg::SLOT_OUT_W'(found_idx_reg);
            end
            else if (is_miss)
            begin
                out_next.slot = ssd_pkg::SLOT_OUT_W'(target);
                out_next.wbv  = full;
                out_next.wbs  = full ? victim_sec_reg : '0;
                out_next.fill = 1'b1;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid            = out_valid_reg;
    assign out_hit              = out_reg.hit;
    assign out_slot             = out_reg.slot;
    assign out_writeback_valid  = out_reg.wbv;
    assign out_writeback_sector = out_reg.wbs;
    assign out_fill_needed      = out_reg.fill;
    assign out_last             = out_reg.last;

endmodule

/* rtl/scored_sector_cache_directory.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scored_sector_cache_directory
// Tag directory of a sector cache with weighted-frequency eviction and aging.
//
//   channel   dir  payload                                         items
//   req       in   opcode, sector, meta_read                       one per request
//   rsp       out  hit, slot, writeback_valid/_sector, fill, last  1..SLOTS per request
//   cfg       in   cfg_write_en, cfg_index, cfg_data               one register write
//
// Every request first walks all slots in the slot memory.
// Hits, free-slot misses and removes then finish once the result register is free.
// A miss in a full cache walks the memory again to score and age.
// A flush reads and then checks each slot in turn, and waits while rsp stalls.
// No clearing pass after reset; requests are taken as soon as rst_n rises.
// ----------------------------------------------------------------------------
module scored_sector_cache_directory #(
    parameter int SLOTS = ssd_pkg::SLOTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  logic [ssd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ssd_pkg::CFG_W-1:0]     cfg_data,
    ssd_req_if.sink                       req,
    ssd_rsp_if.source                     rsp
);

    localparam int SLOT_W = $clog2(SLOTS);

    ssd_pkg::ssd_cmd_t cmd;
    ssd_pkg::ssd_sts_t sts;
    logic [SLOT_W-1:0] rd_addr;
    logic [SLOT_W-1:0] proc_addr;

    // Sequencer
    ssd_ctrl #(.SLOTS(SLOTS)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .proc_addr (proc_addr)
    );

    // Datapath
    ssd_dp #(.SLOTS(SLOTS)) u_dp (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_write_en         (cfg_write_en),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .in_opcode            (req.opcode),
        .in_sector            (req.sector),
        .in_meta_read         (req.meta_read),
        .cmd                  (cmd),
        .rd_addr              (rd_addr),
        .proc_addr            (proc_addr),
        .sts                  (sts),
        .out_ready            (rsp.ready),
        .out_valid            (rsp.valid),
        .out_hit              (rsp.hit),
        .out_slot             (rsp.slot),
        .out_writeback_valid  (rsp.writeback_valid),
        .out_writeback_sector (rsp.writeback_sector),
        .out_fill_needed      (rsp.fill_needed),
        .out_last             (rsp.last)
    );

`include "scored_sector_cache_directory_assert.svh"

    `SSD_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "ready after accept")
    `SSD_ASSERT_IMPL(a_finish_out_free, cmd.finish, sts.out_free, "result overwritten on finish")
    `SSD_ASSERT_IMPL(a_flush_valid_slot, cmd.flush_emit, sts.proc_valid, "flush of empty slot")
    `SSD_ASSERT_IMPL(a_evict_only_full, cmd.evict_step, sts.full, "eviction with free slots")

endmodule

/* sim/scored_sector_cache_directory_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scored_sector_cache_directory_test
// Self-checking bench for the scored sector cache directory. A short table
// of directed requests runs first. It is followed by random request phases,
// each with its own register setting and one of four mixes of sender gaps and
// receiver stalls. Results are compared against a behavioral copy of the
// directory, or against the table's own result for typed rows.
// ----------------------------------------------------------------------------
module scored_sector_cache_directory_test;

    localparam int NSLOT        = ssd_pkg::SLOTS_DEF;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 48;
    localparam int HOLD_CYCLES  = 300;
    localparam int WATCHDOG_MAX = 20000;
    localparam int DRAIN_CYCLES = 2 * NSLOT + 20;
    localparam int POOL_SIZE    = 100;

    typedef struct packed {
        logic                      hit;
        logic [5:0]                slot;
        logic                      wb_valid;
        logic [ssd_pkg::SEC_W-1:0] wb_sector;
        logic                      fill;
        logic                      last;
    } dir_result_t;

    typedef struct {
        logic [ssd_pkg::OP_W-1:0]  op;
        logic [ssd_pkg::SEC_W-1:0] sector;
        logic                      meta;
        logic                      typed;
        dir_result_t               res;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cfg_write_en;
    logic [ssd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [ssd_pkg::CFG_W-1:0] cfg_data;

    ssd_req_if req_bus();
    ssd_rsp_if rsp_bus();

    scored_sector_cache_directory i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req          (req_bus),
        .rsp          (rsp_bus)
    );

    // Shadow directory and registers
    logic [5:0]                shd_init;
    logic [5:0]                shd_aw;
    logic [5:0]                shd_dw;
    logic [5:0]                shd_mw;
    logic                      shd_valid [NSLOT];
    logic [ssd_pkg::SEC_W-1:0] shd_sector [NSLOT];
    logic [5:0]                shd_count [NSLOT];
    logic                      shd_dirty [NSLOT];
    logic                      shd_meta [NSLOT];
    int                        shd_occupied;

    dir_result_t pending_results[$];
    logic        item_typed;
    dir_result_t item_result;

    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_now;
    int  errors;
    int  results_checked;
    int  evictions;
    int  flushes;
    int  items_sent;
    int  idle_cycles;

    logic [ssd_pkg::SEC_W-1:0] sector_pool [POOL_SIZE];
    dir_row_t directed [$];

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Build a single-result expectation with no writeback
    function automatic dir_result_t mk_res(input logic hit, input logic [5:0] slot,
                                           input logic fill);
        dir_result_t r;
        r = '0;
        r.hit = hit;
        r.slot = slot;
        r.fill = fill;
        r.last = 1'b1;
        return r;
    endfunction

    // Compute the results of one request and advance the shadow directory
    task automatic lookup_directory(input logic [ssd_pkg::OP_W-1:0] op,
                                    input logic [ssd_pkg::SEC_W-1:0] sec,
                                    input logic meta, ref dir_result_t res[$]);
        int          found;
        int          target;
        int          last_slot;
        int          best;
        int          score;
        bit          have;
        dir_result_t r;
        found = -1;
        for (int i = 0; i < NSLOT; i++)
            if (found < 0 && shd_valid[i] && shd_sector[i] == sec)
                found = i;
        r = '0;
        r.last = 1'b1;
        if (op == ssd_pkg::OP_FLUSH)
        begin
            flushes++;
            last_slot = -1;
            for (int i = 0; i < NSLOT; i++)
                if (shd_valid[i])
                    last_slot = i;
            if (last_slot < 0)
                res.push_back(r);
            for (int i = 0; i < NSLOT; i++)
            begin
                if (shd_valid[i])
                begin
                    shd_dirty[i] = 1'b0;
                    r.slot = i[5:0];
                    r.wb_valid = 1'b1;
                    r.wb_sector = shd_sector[i];
                    r.last = (i == last_slot);
                    res.push_back(r);
                end
            end
        end
        else if (op == ssd_pkg::OP_REMOVE)
        begin
            if (found >= 0)
            begin
                shd_valid[found] = 1'b0;
                if (shd_occupied > 0)
                    shd_occupied--;
                r.hit = 1'b1;
                r.slot = found[5:0];
            end
            res.push_back(r);
        end
        else if (found >= 0)
        begin
            if (op == ssd_pkg::OP_WRITE)
                shd_dirty[found] = 1'b1;
            if (shd_count[found] < ssd_pkg::COUNT_MAX)
                shd_count[found]++;
            r.hit = 1'b1;
            r.slot = found[5:0];
            res.push_back(r);
        end
        else
        begin
            target = 0;
            if (shd_occupied >= NSLOT)
            begin
                // Score, pick the lowest, age every count
                have = 0;
                best = 0;
                for (int i = 0; i < NSLOT; i++)
                begin
                    if (shd_valid[i])
                    begin
                        score = shd_count[i] * shd_aw + (shd_dirty[i] ? shd_dw : 0)
                              + (shd_meta[i] ? shd_mw : 0);
                        if (!have || score < best)
                        begin
                            have = 1;
                            best = score;
                            target = i;
                        end
                        if (shd_count[i] > 0)
                            shd_count[i]--;
                    end
                end
                r.wb_valid = 1'b1;
                r.wb_sector = shd_sector[target];
                evictions++;
            end
            else
            begin
                target = -1;
                for (int i = 0; i < NSLOT; i++)
                    if (target < 0 && !shd_valid[i])
                        target = i;
                shd_occupied++;
            end
            shd_valid[target] = 1'b1;
            shd_sector[target] = sec;
            shd_dirty[target] = 1'b0;
            shd_meta[target] = (op == ssd_pkg::OP_READ) && meta;
            shd_count[target] = (shd_init == ssd_pkg::COUNT_MAX) ? ssd_pkg::COUNT_MAX
                                                                 : shd_init + 6'd1;
            r.slot = target[5:0];
            r.fill = 1'b1;
            res.push_back(r);
        end
    endtask

    // Predict on accepted requests, check accepted results
    always @(posedge clk)
    begin
        dir_result_t got;
        dir_result_t want;
        dir_result_t produced[$];
        if (rst_n && req_bus.valid && req_bus.ready)
        begin
            produced.delete();
            lookup_directory(req_bus.opcode, req_bus.sector, req_bus.meta_read, produced);
            if (item_typed)
                pending_results.push_back(item_result);
            else
                foreach (produced[k])
                    pending_results.push_back(produced[k]);
        end
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            got = '{rsp_bus.hit, rsp_bus.slot, rsp_bus.writeback_valid,
                    rsp_bus.writeback_sector, rsp_bus.fill_needed, rsp_bus.last};
            results_checked++;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result %p", $time, got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.hit !== want.hit)
                begin
                    errors++;
                    $display("%0t: hit expected %0d actual %0d", $time, want.hit, got.hit);
                end
                if (got.slot !== want.slot)
                begin
                    errors++;
                    $display("%0t: slot expected %0d actual %0d", $time, want.slot, got.slot);
                end
                if (got.wb_valid !== want.wb_valid)
                begin
                    errors++;
                    $display("%0t: writeback_valid expected %0d actual %0d", $time,
                             want.wb_valid, got.wb_valid);
                end
                if (got.wb_sector !== want.wb_sector)
                begin
                    errors++;
                    $display("%0t: writeback_sector expected %h actual %h", $time,
                             want.wb_sector, got.wb_sector);
                end
                if (got.fill !== want.fill)
                begin
                    errors++;
                    $display("%0t: fill_needed expected %0d actual %0d", $time,
                             want.fill, got.fill);
                end
                if (got.last !== want.last)
                begin
                    errors++;
                    $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
                end
            end
        end
    end

    // Watchdog on cycles with no item moving
    always @(posedge clk)
    begin
        if (!rst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_MAX)
        begin
            $display("%0t: watchdog expired, %0d results outstanding", $time,
                     pending_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result receiver: random stalls, one long hold-off on request
    initial
    begin
        rsp_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_now)
            begin
                hold_now = 0;
                rsp_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Offer one item, with random gaps in front of it
    task automatic send_item(input dir_row_t row);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.opcode <= row.op;
        req_bus.sector <= row.sector;
        req_bus.meta_read <= row.meta;
        item_typed <= row.typed;
        item_result <= row.res;
        do @(posedge clk); while (!(req_bus.valid && req_bus.ready));
        items_sent++;
    endtask

    // Wait until every result is taken and the block is idle again
    task automatic wait_drained();
        @(posedge clk);
        while (pending_results.size() != 0 || !req_bus.ready)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [ssd_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [5:0] value);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            ssd_pkg::CFG_INIT_COUNT:    shd_init = value;
            ssd_pkg::CFG_ACCESS_WEIGHT: shd_aw = value;
            ssd_pkg::CFG_DIRTY_WEIGHT:  shd_dw = value;
            default:                    shd_mw = value;
        endcase
    endtask

    task automatic add_row(input logic [ssd_pkg::OP_W-1:0] op,
                           input logic [ssd_pkg::SEC_W-1:0] sec,
                           input logic meta, input logic typed, input dir_result_t res);
        dir_row_t row;
        row.op = op;
        row.sector = sec;
        row.meta = meta;
        row.typed = typed;
        row.res = res;
        directed.push_back(row);
    endtask

    // Main sequence
    initial
    begin
        dir_row_t   row;
        int         pick;
        logic [5:0] cfg_set [4];
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = ssd_pkg::CFG_INIT_COUNT;
        cfg_data = '0;
        req_bus.valid = 1'b0;
        req_bus.opcode = ssd_pkg::OP_READ;
        req_bus.sector = '0;
        req_bus.meta_read = 1'b0;
        item_typed = 1'b0;
        item_result = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_now = 0;
        errors = 0;
        results_checked = 0;
        evictions = 0;
        flushes = 0;
        items_sent = 0;
        idle_cycles = 0;
        shd_init = ssd_pkg::INIT_COUNT_RST;
        shd_aw = ssd_pkg::ACCESS_WEIGHT_RST;
        shd_dw = ssd_pkg::DIRTY_WEIGHT_RST;
        shd_mw = ssd_pkg::META_WEIGHT_RST;
        shd_occupied = 0;
        for (int i = 0; i < NSLOT; i++)
        begin
            shd_valid[i] = 1'b0;
            shd_sector[i] = '0;
            shd_count[i] = '0;
            shd_dirty[i] = 1'b0;
            shd_meta[i] = 1'b0;
        end
        for (int i = 0; i < POOL_SIZE; i++)
            sector_pool[i] = $urandom;

        // Directed table: empty flush, extremes of the sector, every opcode
        add_row(ssd_pkg::OP_FLUSH,  32'h0000_0000, 1'b0, 1'b1, mk_res(1'b0, 6'd0, 1'b0));
        add_row(ssd_pkg::OP_REMOVE, 32'hFFFF_FFFF, 1'b0, 1'b1, mk_res(1'b0, 6'd0, 1'b0));
        add_row(ssd_pkg::OP_READ,   32'h0000_0000, 1'b1, 1'b1, mk_res(1'b0, 6'd0, 1'b1));
        add_row(ssd_pkg::OP_WRITE,  32'hFFFF_FFFF, 1'b0, 1'b1, mk_res(1'b0, 6'd1, 1'b1));
        add_row(ssd_pkg::OP_READ,   32'h0000_0000, 1'b0, 1'b1, mk_res(1'b1, 6'd0, 1'b0));
        add_row(ssd_pkg::OP_WRITE,  32'h0000_0000, 1'b1, 1'b1, mk_res(1'b1, 6'd0, 1'b0));
        add_row(ssd_pkg::OP_WRITE,  32'h8000_0000, 1'b1, 1'b0, '0);
        add_row(ssd_pkg::OP_READ,   32'h7FFF_FFFF, 1'b0, 1'b0, '0);
        add_row(ssd_pkg::OP_REMOVE, 32'hFFFF_FFFF, 1'b0, 1'b1, mk_res(1'b1, 6'd1, 1'b0));
        add_row(ssd_pkg::OP_READ,   32'h1234_5678, 1'b1, 1'b0, '0);
        add_row(ssd_pkg::OP_FLUSH,  32'hFFFF_FFFF, 1'b1, 1'b0, '0);
        add_row(ssd_pkg::OP_WRITE,  32'h5555_5555, 1'b0, 1'b0, '0);
        add_row(ssd_pkg::OP_READ,   32'hAAAA_AAAA, 1'b1, 1'b0, '0);
        add_row(ssd_pkg::OP_READ,   32'h5555_5555, 1'b1, 1'b0, '0);
        add_row(ssd_pkg::OP_REMOVE, 32'h5555_5555, 1'b0, 1'b0, '0);
        add_row(ssd_pkg::OP_REMOVE, 32'h5555_5555, 1'b1, 1'b0, '0);
        add_row(ssd_pkg::OP_FLUSH,  32'h0000_0000, 1'b0, 1'b0, '0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[k])
            send_item(directed[k]);
        req_bus.valid <= 1'b0;

        for (int p = 0; p < PHASES; p++)
        begin
            // Drain, then reprogram while idle
            wait_drained();
            repeat (4) @(posedge clk);
            case (p)
                0:       cfg_set = '{6'd62, 6'd63, 6'd63, 6'd63};
                1:       cfg_set = '{6'd0, 6'd0, 6'd0, 6'd0};
                2:       cfg_set = '{6'd63, 6'd1, 6'd63, 6'd0};
                3:       cfg_set = '{ssd_pkg::INIT_COUNT_RST, ssd_pkg::ACCESS_WEIGHT_RST,
                                     ssd_pkg::DIRTY_WEIGHT_RST, ssd_pkg::META_WEIGHT_RST};
                default: cfg_set = '{6'($urandom_range(63)), 6'($urandom_range(63)),
                                     6'($urandom_range(63)), 6'($urandom_range(63))};
            endcase
            write_register(ssd_pkg::CFG_INIT_COUNT, cfg_set[0]);
            write_register(ssd_pkg::CFG_ACCESS_WEIGHT, cfg_set[1]);
            write_register(ssd_pkg::CFG_DIRTY_WEIGHT, cfg_set[2]);
            write_register(ssd_pkg::CFG_META_WEIGHT, cfg_set[3]);
            cfg_write_en <= 1'b0;
            send_idle_pct = (p % 4 == 1) ? 82 : (p % 4 == 3) ? 14 : 0;
            recv_stall_pct = (p % 4 == 2) ? 82 : (p % 4 == 3) ? 14 : 0;
            if (p == 4)
                hold_now = 1;

            // Mostly reuse a pool larger than the cache so it fills and evicts
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(99);
                row.op = (pick < 50) ? ssd_pkg::OP_READ : (pick < 85) ? ssd_pkg::OP_WRITE :
                         (pick < 95) ? ssd_pkg::OP_REMOVE : ssd_pkg::OP_FLUSH;
                row.sector = ($urandom_range(9) == 0) ? $urandom
                                                      : sector_pool[$urandom_range(POOL_SIZE-1)];
                row.meta = 1'($urandom_range(1));
                row.typed = 1'b0;
                row.res = '0;
                send_item(row);
            end
            req_bus.valid <= 1'b0;
        end

        // Let everything drain, then watch for strays
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests over %0d register settings; checked %0d results",
                 items_sent, PHASES, results_checked);
        $display("Covered %0d evictions and %0d flushes; %0d mismatches",
                 evictions, flushes, errors);
        if (errors == 0 && pending_results.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* scored_sector_cache_directory.f */
+incdir+rtl
rtl/ssd_pkg.sv
rtl/ssd_req_if.sv
rtl/ssd_rsp_if.sv
rtl/ssd_ctrl.sv
rtl/ssd_dp.sv
rtl/scored_sector_cache_directory.sv
sim/scored_sector_cache_directory_test.sv
